@@ rtl/pcsb_pkg.sv @@
// Package for the point cloud to scan binner: constants, state codes, config indexes,
// and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcsb_pkg;
	localparam int ScanBinsDefault = 1024;
	localparam int CordicStepsDefault = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int ReadBinW = 10;
	localparam int BinCountW = 11;
	localparam int AngW = 18;
	localparam int CordW = 34;
	localparam int SqW = 34;
	localparam logic signed [AngW-1:0] PiQ13 = 18'sd25736;
	localparam logic signed [AngW-1:0] HalfPiQ13 = 18'sd12868;
	localparam logic signed [AngW-1:0] TwoPiQ13 = 18'sd51472;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_Z_LOW = 3'd0, CFG_Z_HIGH = 3'd1, CFG_RANGE_LOW = 3'd2, CFG_RANGE_HIGH = 3'd3,
		CFG_ANGLE_LOW = 3'd4, CFG_ANGLE_HIGH = 3'd5, CFG_BPR = 3'd6, CFG_BIN_COUNT = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_RFILT, ST_CORDIC, ST_AFILT, ST_MUL, ST_BIN,
		ST_RD, ST_UPD, ST_OUT, ST_CLR
	} state_t;

	typedef enum logic {OP_ADD = 1'b0, OP_READ = 1'b1} opcode_t;

	function automatic logic signed [AngW-1:0] atan_q13(input logic [4:0] i);
		logic signed [AngW-1:0] r;
		case (i)
			5'd0: r = 18'sd6434;
			5'd1: r = 18'sd3798;
			5'd2: r = 18'sd2007;
			5'd3: r = 18'sd1019;
			5'd4: r = 18'sd511;
			5'd5: r = 18'sd256;
			5'd6: r = 18'sd128;
			5'd7: r = 18'sd64;
			5'd8: r = 18'sd32;
			5'd9: r = 18'sd16;
			5'd10: r = 18'sd8;
			5'd11: r = 18'sd4;
			5'd12: r = 18'sd2;
			5'd13: r = 18'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/pcsb_if.sv @@
// Valid/ready channel interfaces for the binner: point/read input and bin result output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pcsb_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [15:0] x_mm;
	logic signed [15:0] y_mm;
	logic signed [15:0] z_mm;
	logic coord_missing;
	logic [9:0] read_bin;
	modport source(output valid, opcode, x_mm, y_mm, z_mm, coord_missing, read_bin,
		input ready);
	modport sink(input valid, opcode, x_mm, y_mm, z_mm, coord_missing, read_bin,
		output ready);
endinterface

interface pcsb_out_if;
	logic valid;
	logic ready;
	logic [15:0] range_mm;
	logic bin_hit;
	modport source(output valid, range_mm, bin_hit, input ready);
	modport sink(input valid, range_mm, bin_hit, output ready);
endinterface
`default_nettype wire

@@ rtl/pointcloud_to_scan_binner.sv @@
// Point cloud to scan binner top level: sequencer, shared step unit, bin memory.
// Depends on pcsb_pkg and pcsb_if.
// An add word passes through the squares, the square root, RFILT, the CORDIC, AFILT,
// MUL, BIN and UPD, then returns to idle before the next word is taken; a read
// word passes through RD and OUT plus output wait. Dropped points leave early.
// The square root gives one result bit a cycle and the CORDIC one rotation a cycle,
// both on the same single step unit. One word is in work at a time;
// a finished read waits in the result register while the next word is taken, and a
// later read holds in its last cycle until that register is free.
// The bin memory keeps a hit flag beside each range; after reset a clearing pass over
// every bin empties it before the first word is taken.
`timescale 1ns / 1ps
`default_nettype none
module pointcloud_to_scan_binner #(
	parameter int SCAN_BINS = pcsb_pkg::ScanBinsDefault,
	parameter int CORDIC_STEPS = pcsb_pkg::CordicStepsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	pcsb_in_if.sink in_ch,
	pcsb_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [pcsb_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [pcsb_pkg::CfgDataW-1:0] cfg_data
);
	import pcsb_pkg::*;
	localparam int BinW = $clog2(SCAN_BINS);
	localparam int StepW = 5;
	localparam int MemW = 17;

	state_t state_q, state_d;
	logic signed [15:0] z_low_q, z_high_q, angle_low_q, angle_high_q;
	logic [15:0] range_low_q, range_high_q, bpr_q;
	logic [BinCountW-1:0] bin_count_q;

	logic signed [15:0] x_q, y_q, z_q;
	logic [ReadBinW-1:0] rbin_q;
	logic [SqW-1:0] sq_q, rem_q;
	logic [SqW-1:0] root_q;
	logic [StepW-1:0] cnt_q;
	logic signed [CordW-1:0] cx_q, cy_q;
	logic signed [AngW-1:0] acc_q;
	logic signed [35:0] t_q;
	logic [15:0] dist_q;
	logic [BinW-1:0] idx_q;
	logic [MemW-1:0] mem [SCAN_BINS];
	logic [MemW-1:0] rd_q;
	logic [MemW-1:0] rdmem_q;
	logic [BinW-1:0] clr_q;
	logic mem_we;
	logic [BinW-1:0] wr_addr;
	logic [MemW-1:0] wr_data;
	logic [BinW-1:0] rd_idx;
	logic out_free;
	logic [15:0] res_range_q;
	logic res_hit_q, res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_low_q <= 16'sd0;
			z_high_q <= 16'sd2000;
			range_low_q <= 16'd100;
			range_high_q <= 16'd65535;
			angle_low_q <= -16'sd25723;
			angle_high_q <= 16'sd25723;
			bpr_q <= 16'd25600;
			bin_count_q <= 11'd629;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_Z_LOW: z_low_q <= cfg_data;
				CFG_Z_HIGH: z_high_q <= cfg_data;
				CFG_RANGE_LOW: range_low_q <= cfg_data;
				CFG_RANGE_HIGH: range_high_q <= cfg_data;
				CFG_ANGLE_LOW: angle_low_q <= cfg_data;
				CFG_ANGLE_HIGH: angle_high_q <= cfg_data;
				CFG_BPR: bpr_q <= cfg_data;
				CFG_BIN_COUNT: bin_count_q <= cfg_data[BinCountW-1:0];
				default: ;
			endcase
		end
	end

	// shared step unit: square accumulate, sqrt bit, CORDIC rotate, bin multiply
	logic signed [15:0] sq_op;
	logic signed [31:0] sq_prod;
	logic [SqW-1:0] trial;
	logic [5:0] bit_pos;
	logic signed [CordW-1:0] sx, sy;
	logic signed [AngW-1:0] acc_cl, ang_adj, ang_diff;
	logic wrapped, ang_drop, z_ok, in_read_range;
	logic [15:0] dist_sat;
	logic [BinCountW:0] limit;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign wrapped = angle_low_q > angle_high_q;
	assign rd_idx = BinW'(rbin_q);
	assign out_free = !res_v_q || out_ch.ready;

	always_comb begin
		sq_op = (cnt_q == 5'd0) ? x_q : (cnt_q == 5'd1) ? y_q : z_q;
		sq_prod = sq_op * sq_op;
		bit_pos = {cnt_q, 1'b0};
		trial = root_q + (SqW'(1) << bit_pos);
		sx = cx_q >>> cnt_q;
		sy = cy_q >>> cnt_q;
		z_ok = (z_q >= z_low_q) && (z_q <= z_high_q);
		dist_sat = (root_q > SqW'(65535)) ? 16'hFFFF : root_q[15:0];
		acc_cl = (acc_q > PiQ13) ? PiQ13 : (acc_q < -PiQ13) ? -PiQ13 : acc_q;
		ang_drop = wrapped ? ((acc_cl < AngW'(angle_low_q)) && (acc_cl > AngW'(angle_high_q)))
			: ((acc_cl < AngW'(angle_low_q)) || (acc_cl > AngW'(angle_high_q)));
		ang_adj = (wrapped && acc_q < AngW'(angle_high_q) && acc_q > -PiQ13)
			? acc_q + TwoPiQ13 : acc_q;
		ang_diff = ang_adj - AngW'(angle_low_q);
		limit = (bin_count_q < BinCountW'(SCAN_BINS)) || (SCAN_BINS > 2047)
			? {1'b0, bin_count_q} : (BinCountW+1)'(SCAN_BINS);
		in_read_range = (32'(rbin_q) < SCAN_BINS);
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		wr_addr = idx_q;
		wr_data = {1'b1, dist_q};
		unique case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == BinW'(SCAN_BINS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				if (in_ch.opcode == OP_READ) state_d = ST_RD;
				else if (in_ch.coord_missing) state_d = ST_IDLE;
				else state_d = ST_SQ;
			end
			ST_SQ: if (!z_ok) state_d = ST_IDLE;
				else if (cnt_q == 5'd2) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == 5'd0) state_d = ST_RFILT;
			ST_RFILT: state_d = (dist_sat < range_low_q || dist_sat > range_high_q)
				? ST_IDLE : ST_CORDIC;
			ST_CORDIC: if (32'(cnt_q) == CORDIC_STEPS - 1 || (cx_q == 0 && cy_q == 0))
				state_d = ST_AFILT;
			ST_AFILT: state_d = ang_drop ? ST_IDLE : ST_MUL;
			ST_MUL: state_d = ST_BIN;
			ST_BIN: begin
				if (t_q <= -36'sd2097152 || (t_q < 0 && limit == '0)
					|| (t_q >= 0 && (t_q >>> 21) >= 36'(limit)))
					state_d = ST_IDLE;
				else state_d = ST_UPD;
			end
			ST_RD: state_d = ST_OUT;
			ST_UPD: begin
				if (!rd_q[MemW-1] || dist_q < rd_q[15:0]) mem_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_OUT: if (out_free) begin
				if (in_read_range) begin
					mem_we = 1'b1;
					wr_addr = rd_idx;
					wr_data = '0;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= in_ch.x_mm;
				y_q <= in_ch.y_mm;
				z_q <= in_ch.z_mm;
				rbin_q <= in_ch.read_bin;
				sq_q <= '0;
				cnt_q <= '0;
				root_q <= '0;
			end
			ST_SQ: begin
				sq_q <= sq_q + SqW'($unsigned(sq_prod));
				cnt_q <= (cnt_q == 5'd2) ? 5'd16 : cnt_q + 5'd1;
				rem_q <= sq_q + SqW'($unsigned(sq_prod));
			end
			ST_SQRT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					root_q <= (root_q >> 1) + (SqW'(1) << bit_pos);
				end else root_q <= root_q >> 1;
				if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
			end
			ST_RFILT: begin
				dist_q <= dist_sat;
				cnt_q <= '0;
				acc_q <= '0;
				if (x_q < 0) begin
					if (y_q >= 0) begin
						cx_q <= CordW'(y_q) <<< 8;
						cy_q <= -(CordW'(x_q) <<< 8);
						acc_q <= HalfPiQ13;
					end else begin
						cx_q <= -(CordW'(y_q) <<< 8);
						cy_q <= CordW'(x_q) <<< 8;
						acc_q <= -HalfPiQ13;
					end
				end else begin
					cx_q <= CordW'(x_q) <<< 8;
					cy_q <= CordW'(y_q) <<< 8;
				end
			end
			ST_CORDIC: if (!(cx_q == 0 && cy_q == 0)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					acc_q <= acc_q + atan_q13(cnt_q);
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					acc_q <= acc_q - atan_q13(cnt_q);
				end
				cnt_q <= cnt_q + 5'd1;
			end
			ST_AFILT: acc_q <= acc_cl;
			ST_MUL: t_q <= 36'(ang_diff) * 36'($signed({1'b0, bpr_q})) + 36'sd1048576;
			ST_BIN: begin
				idx_q <= (t_q < 0) ? '0 : BinW'(t_q >>> 21);
				rd_q <= mem[(t_q < 0) ? '0 : BinW'(t_q >>> 21)];
			end
			default: ;
		endcase
		if (mem_we) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rdmem_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			res_v_q <= 1'b0;
			res_hit_q <= 1'b0;
			res_range_q <= '0;
		end else begin
			if (state_q == ST_CLR) clr_q <= clr_q + BinW'(1);
			if (state_q == ST_OUT && out_free) begin
				res_v_q <= 1'b1;
				res_hit_q <= in_read_range && rdmem_q[MemW-1];
				res_range_q <= (in_read_range && rdmem_q[MemW-1]) ? rdmem_q[15:0]
					: range_high_q;
			end else if (res_v_q && out_ch.ready) res_v_q <= 1'b0;
		end
	end

	assign out_ch.valid = res_v_q;
	assign out_ch.range_mm = res_range_q;
	assign out_ch.bin_hit = res_hit_q;
endmodule
`default_nettype wire

@@ rtl/pcsb_checker.sv @@
// Port-level checker for the binner, bound to the top level.
// Imports no package.
`timescale 1ns / 1ps
`default_nettype none
module pcsb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic bin_hit
);
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready)) else $error("ready unknown");
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid)) else $error("result valid unknown");
	a_hit_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(bin_hit)) else $error("hit flag unknown");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(bin_hit))
		else $error("result dropped");
endmodule

bind pointcloud_to_scan_binner pcsb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .bin_hit(out_ch.bin_hit));
`default_nettype wire
